FILE: rtl/running_min_max_mean_tracker_assert.svh
// assertion macros for the running min max mean tracker
`ifndef RUNNING_MIN_MAX_MEAN_TRACKER_ASSERT_SVH
`define RUNNING_MIN_MAX_MEAN_TRACKER_ASSERT_SVH

// same-cycle implication under reset
`define RMMT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define RMMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rmmt_pkg.sv
// shared types and constants for the running min max mean tracker
package rmmt_pkg;

  localparam int MEAN_FRAC_BITS = 6;

  typedef enum logic {
    CMD_CLEAR  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rmmt_div_status_t;

endpackage

FILE: rtl/running_min_max_mean_tracker.sv
// running min, max and mean statistics over converter samples
// in channel: in_tuser is the command (0 clears, 1 takes a sample), in_tdata
//   carries the sample code. out channel: one result item per input item,
//   showing the statistics after that item.
// a sample item passes from acceptance through the divide and load states
//   to the result register; the bit-serial divider forms the mean, one
//   quotient bit per cycle over the shifted sum.
// a clear item passes through the load state to the result register.
// in_tready is high only while no item is in progress; the next item is
//   accepted while the previous result still waits in the output register,
//   but the block never takes a new item before it is through with the last.
// if the receiver stalls, the result holds in the output register and the
//   block finishes the current item, then waits before loading the next one.
// synchronous reset (rst_n low) clears all statistics: minimum reads
//   2^SAMPLE_BITS, all other values 0, and no result is pending.
`include "running_min_max_mean_tracker_assert.svh"

module running_min_max_mean_tracker
  import rmmt_pkg::*;
#(
  parameter int SAMPLE_BITS = 10,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,   // sample_code
  input  logic                                  in_tuser,   // command
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // latest_code, minimum_code, maximum_code, mean_code, sample_count
  output logic [((4*SAMPLE_BITS+7+COUNT_BITS+7)/8)*8-1:0] out_tdata
);

  localparam int S      = SAMPLE_BITS;
  localparam int C      = COUNT_BITS;
  localparam int SW     = S + C;
  localparam int MW     = S + MEAN_FRAC_BITS;
  localparam int DW     = SW + MEAN_FRAC_BITS;
  localparam int FLD_W  = 4 * S + 7 + C;
  localparam int OUT_W  = ((FLD_W + 7) / 8) * 8;
  localparam logic [C-1:0] COUNT_MAX = {C{1'b1}};
  localparam logic [S:0]   MIN_INIT  = {1'b1, {S{1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [S-1:0]     latest_r, latest_nxt;
  logic [S:0]       min_r, min_nxt;
  logic [S-1:0]     max_r, max_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;
  logic [C-1:0]     count_r, count_nxt;
  logic [MW-1:0]    mean_r, mean_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic [S-1:0]     code;
  logic             div_start;
  logic [MW-1:0]    quotient;
  rmmt_div_status_t div_status;

  assign code = in_tdata[S-1:0];

  rmmt_divider #(
    .DIVIDEND_BITS (DW),
    .DIVISOR_BITS  (C),
    .QUOTIENT_BITS (MW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_nxt, {MEAN_FRAC_BITS{1'b0}}}),
    .divisor  (count_nxt),
    .quotient (quotient),
    .status   (div_status)
  );

  always_comb begin
    state_nxt     = state_r;
    latest_nxt    = latest_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    mean_nxt      = mean_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == CMD_CLEAR) begin
            latest_nxt = '0;
            min_nxt    = MIN_INIT;
            max_nxt    = '0;
            sum_nxt    = '0;
            count_nxt  = '0;
            mean_nxt   = '0;
            state_nxt  = ST_LOAD;
          end else begin
            latest_nxt = code;
            if (code > max_r) begin
              max_nxt = code;
            end
            if ({1'b0, code} < min_r) begin
              min_nxt = {1'b0, code};
            end
            if (count_r != COUNT_MAX) begin
              count_nxt = count_r + C'(1);
              sum_nxt   = sum_r + SW'(code);
            end
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          mean_nxt  = quotient;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({count_r, mean_r, max_r, min_r, latest_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      latest_r    <= '0;
      min_r       <= MIN_INIT;
      max_r       <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      mean_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      latest_r    <= latest_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      mean_r      <= mean_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `RMMT_ASSERT_IMPLY(a_ready_div_idle, clk, rst_n, in_tready, !div_status.busy,
    "input ready while divider busy")
  `RMMT_ASSERT_IMPLY(a_done_in_div, clk, rst_n, div_status.done, state_r == ST_DIV,
    "divider done outside divide state")
  `RMMT_ASSERT_IMPLY(a_empty_sum, clk, rst_n, count_r == '0, sum_r == '0,
    "nonzero sum with zero count")
  `RMMT_ASSERT_IMPLY(a_min_le_max, clk, rst_n, count_r != '0, min_r <= {1'b0, max_r},
    "minimum above maximum")
  `RMMT_ASSERT_NEXT(a_sample_starts_div, clk, rst_n, div_start, div_status.busy,
    "divider did not start")

endmodule

FILE: rtl/rmmt_divider.sv
// iterative restoring divider, one quotient bit per cycle
module rmmt_divider
  import rmmt_pkg::*;
#(
  parameter int DIVIDEND_BITS = 32,
  parameter int DIVISOR_BITS  = 16,
  parameter int QUOTIENT_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic [QUOTIENT_BITS-1:0] quotient,
  output rmmt_div_status_t         status
);

  localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] dq_r, dq_nxt;
  logic [DIVISOR_BITS-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_BITS-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [DIVISOR_BITS:0]    shifted;
  logic [DIVISOR_BITS:0]    diff;
  logic                     ge;

  assign shifted = {rem_r, dq_r[DIVIDEND_BITS-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIVIDEND_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DIVIDEND_BITS-2:0], ge};
      rem_nxt = ge ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient    = dq_r[QUOTIENT_BITS-1:0];
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

FILE: bench/running_min_max_mean_tracker_test.sv
// testbench for the running min max mean tracker: directed table and random samples
module running_min_max_mean_tracker_test
  import rmmt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [15:0] COUNT_FULL = 16'hFFFF;

  // packed from the highest field down, so latest sits in the lowest bits
  typedef struct packed {
    logic [15:0] count;
    logic [15:0] mean;
    logic [9:0]  maxc;
    logic [10:0] minc;
    logic [9:0]  latest;
  } stats_t;

  typedef struct {
    cmd_t        cmd;
    logic [9:0]  code;
    bit          pinned;
    stats_t      want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // sample_code
  logic        in_tuser;   // command
  logic        out_tvalid;
  logic        out_tready;
  // latest_code, minimum_code, maximum_code, mean_code, sample_count
  logic [63:0] out_tdata;

  running_min_max_mean_tracker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // tracker state mirrored by the bench
  logic [9:0]  last_code = '0;
  logic [10:0] low_code  = 11'd1024;
  logic [9:0]  high_code = '0;
  logic [25:0] sum_acc   = '0;
  logic [15:0] n_taken   = '0;
  logic [15:0] mean_acc  = '0;

  stats_t expected_stats [$];
  bit     pin_on = 1'b0;
  stats_t pin_val;
  bit     idle_on = 1'b1;
  int     quiet_left = 0;
  int     err_count = 0;
  int     quiet_cycles = 0;
  int     n_clears = 0;
  int     n_samples = 0;
  row_t   plan [21];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic stats_t mk(input int latest, input int minc, input int maxc,
                                input int mean, input int count);
    stats_t s;
    s.latest = latest[9:0];
    s.minc   = minc[10:0];
    s.maxc   = maxc[9:0];
    s.mean   = mean[15:0];
    s.count  = count[15:0];
    return s;
  endfunction

  task automatic track_item(input cmd_t cmd, input logic [9:0] code, output stats_t res);
    logic [63:0] scaled;
    if (cmd == CMD_CLEAR) begin
      last_code = '0;
      low_code  = 11'd1024;
      high_code = '0;
      sum_acc   = '0;
      n_taken   = '0;
      mean_acc  = '0;
    end else begin
      last_code = code;
      if (code > high_code) high_code = code;
      if ({1'b0, code} < low_code) low_code = {1'b0, code};
      if (n_taken != COUNT_FULL) begin
        n_taken = n_taken + 16'd1;
        sum_acc = sum_acc + 26'(code);
      end
      if (n_taken != 0) begin
        scaled = (64'(sum_acc) << MEAN_FRAC_BITS) / 64'(n_taken);
        mean_acc = scaled[15:0];
      end else begin
        mean_acc = '0;
      end
    end
    res = mk(last_code, low_code, high_code, mean_acc, n_taken);
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= 20)
      $display("mismatch on %s: got %0d, want %0d", what, got, want);
  endtask

  always @(posedge clk) begin : watch
    stats_t got;
    stats_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        track_item(cmd_t'(in_tuser), in_tdata[9:0], want);
        if (pin_on) want = pin_val;
        expected_stats.push_back(want);
        if (in_tuser == CMD_CLEAR) n_clears++;
        else n_samples++;
      end
      if (out_tvalid && out_tready) begin
        got = stats_t'(out_tdata[62:0]);
        if (expected_stats.size() == 0) begin
          flag_mismatch("result with no item pending", got.count, 0);
        end else begin
          want = expected_stats.pop_front();
          if (got.latest != want.latest)
            flag_mismatch("latest_code", got.latest, want.latest);
          if (got.minc != want.minc)
            flag_mismatch("minimum_code", got.minc, want.minc);
          if (got.maxc != want.maxc)
            flag_mismatch("maximum_code", got.maxc, want.maxc);
          if (got.mean != want.mean)
            flag_mismatch("mean_code", got.mean, want.mean);
          if (got.count != want.count)
            flag_mismatch("sample_count", got.count, want.count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no progress for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // receiver backpressure
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 99) < 20) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 99) == 0) begin
        repeat ($urandom_range(20, 200)) @(negedge clk);
      end
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [9:0] code,
                           input bit pin, input stats_t pv);
    pin_on  = pin;
    pin_val = pv;
    if (idle_on && quiet_left == 0 && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, code};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (quiet_left > 0) quiet_left--;
    else if (idle_on && $urandom_range(0, 49) == 0) quiet_left = $urandom_range(10, 40);
  endtask

  task automatic wait_drained();
    while (expected_stats.size() != 0) @(negedge clk);
  endtask

  function automatic logic [9:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 10'd0;
    if (r < 30) return 10'd1023;
    if (r < 35) return 10'($urandom_range(0, 3));
    if (r < 40) return 10'($urandom_range(1020, 1023));
    return 10'($urandom_range(0, 1023));
  endfunction

  initial begin
    stats_t none;
    stats_t cleared;
    none    = '0;
    cleared = mk(0, 1024, 0, 0, 0);
    plan = '{
      '{CMD_CLEAR,  10'd0,    1'b1, cleared},
      '{CMD_SAMPLE, 10'd0,    1'b1, mk(0, 0, 0, 0, 1)},
      '{CMD_SAMPLE, 10'd1023, 1'b1, mk(1023, 0, 1023, 32736, 2)},
      '{CMD_SAMPLE, 10'd1023, 1'b0, none},
      '{CMD_SAMPLE, 10'd0,    1'b0, none},
      '{CMD_SAMPLE, 10'd512,  1'b0, none},
      '{CMD_CLEAR,  10'd1023, 1'b1, cleared},
      '{CMD_SAMPLE, 10'd1023, 1'b1, mk(1023, 1023, 1023, 65472, 1)},
      '{CMD_SAMPLE, 10'd1,    1'b0, none},
      '{CMD_SAMPLE, 10'h2AA,  1'b0, none},
      '{CMD_SAMPLE, 10'h155,  1'b0, none},
      '{CMD_CLEAR,  10'h155,  1'b1, cleared},
      '{CMD_CLEAR,  10'h2AA,  1'b1, cleared},
      '{CMD_SAMPLE, 10'd1,    1'b0, none},
      '{CMD_SAMPLE, 10'd1,    1'b0, none},
      '{CMD_SAMPLE, 10'd2,    1'b0, none},
      '{CMD_SAMPLE, 10'd1,    1'b0, none},
      '{CMD_SAMPLE, 10'd2,    1'b0, none},
      '{CMD_SAMPLE, 10'd1022, 1'b0, none},
      '{CMD_CLEAR,  10'd0,    1'b1, cleared},
      '{CMD_SAMPLE, 10'd700,  1'b1, mk(700, 700, 700, 44800, 1)}
    };

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = CMD_CLEAR;
    in_tdata  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) send_item(plan[i].cmd, plan[i].code, plan[i].pinned, plan[i].want);

    in_tvalid <= 1'b0;
    wait_drained();

    for (int i = 0; i < 650; i++) begin
      if (i == 550) idle_on = 1'b0;
      if (idle_on && $urandom_range(0, 99) == 0) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
        wait_drained();
      end
      if ($urandom_range(0, 99) < 5)
        send_item(CMD_CLEAR, 10'($urandom_range(0, 1023)), 1'b0, none);
      else
        send_item(CMD_SAMPLE, pick_code(), 1'b0, none);
    end

    // extremes right before the end
    send_item(CMD_SAMPLE, 10'd0, 1'b0, none);
    send_item(CMD_SAMPLE, 10'd1023, 1'b0, none);
    send_item(CMD_SAMPLE, 10'($urandom_range(0, 1023)), 1'b0, none);
    send_item(CMD_CLEAR, 10'd0, 1'b0, none);
    send_item(CMD_SAMPLE, pick_code(), 1'b0, none);

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk);
    if (expected_stats.size() != 0)
      flag_mismatch("results never delivered", expected_stats.size(), 0);

    $display("covered %0d clear items and %0d sample items, extremes and equal codes",
             n_clears, n_samples);
    $display("receiver stalls, sender gaps and full drains exercised, %0d mismatches",
             err_count);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
